// File: rtl/scd_pkg.sv
// shared constants and operation codes of the sector cache directory
package scd_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam int MAX_SECTOR_BYTES_DEF = 512;
  localparam int DEVICE_ID_BITS_DEF = 8;

  localparam int OP_W = 2;
  localparam int DEV_PORT_W = 8;
  localparam int BLK_W = 64;
  localparam int BYTES_W = 13;
  localparam int SLOT_W = 6;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;

  localparam logic [OP_W-1:0] OP_GET = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;
endpackage

// File: rtl/scd_cell.sv
// one directory entry of the rotating ring
module scd_cell #(
  parameter int DEVICE_ID_BITS = scd_pkg::DEVICE_ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic                        valid_in,
  input  logic [DEVICE_ID_BITS-1:0]   dev_in,
  input  logic [scd_pkg::BLK_W-1:0]   blk_in,
  input  logic [scd_pkg::STAMP_W-1:0] stamp_in,
  output logic                        valid_out,
  output logic [DEVICE_ID_BITS-1:0]   dev_out,
  output logic [scd_pkg::BLK_W-1:0]   blk_out,
  output logic [scd_pkg::STAMP_W-1:0] stamp_out
);
  import scd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
      dev_out   <= '0;
      blk_out   <= '0;
      stamp_out <= '0;
    end else if (shift) begin
      valid_out <= valid_in;
      dev_out   <= dev_in;
      blk_out   <= blk_in;
      stamp_out <= stamp_in;
    end
  end
endmodule

// File: rtl/sector_cache_directory_lru.sv
// top level: lru tag directory of a fully associative sector cache
//
//  channel | handshake          | word
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_stall  | operation, device_id, block_address, sector_bytes
//  out     | out_valid/out_stall| hit, slot, rejected, hit_total, miss_total
//
// get, invalidate and flush make one scan pass over the entry ring, a put
// makes a scan pass and then a write pass, a rejected put makes no pass; the
// ring rotates one entry past the scan head per cycle
// reset clears every entry at once, no clearing pass is needed
// a finished word waits in the output register; the scan of the next word
// may run meanwhile and holds its result until the register frees up
module sector_cache_directory_lru #(
  parameter int ENTRIES          = scd_pkg::ENTRIES_DEF,
  parameter int MAX_SECTOR_BYTES = scd_pkg::MAX_SECTOR_BYTES_DEF,
  parameter int DEVICE_ID_BITS   = scd_pkg::DEVICE_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [scd_pkg::OP_W-1:0]       operation,
  input  logic [scd_pkg::DEV_PORT_W-1:0] device_id,
  input  logic [scd_pkg::BLK_W-1:0]      block_address,
  input  logic [scd_pkg::BYTES_W-1:0]    sector_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [scd_pkg::SLOT_W-1:0]     slot,
  output logic                           rejected,
  output logic [scd_pkg::COUNT_W-1:0]    hit_total,
  output logic [scd_pkg::COUNT_W-1:0]    miss_total
);
  import scd_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(MAX_SECTOR_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // ring of entries; cell k takes from cell k+1, the head is cell 0
  logic                      cv [ENTRIES];
  logic [DEVICE_ID_BITS-1:0] cd [ENTRIES];
  logic [BLK_W-1:0]          cb [ENTRIES];
  logic [STAMP_W-1:0]        cs [ENTRIES];

  logic                      wb_valid;
  logic [DEVICE_ID_BITS-1:0] wb_dev;
  logic [BLK_W-1:0]          wb_blk;
  logic [STAMP_W-1:0]        wb_stamp;
  logic                      shift;

  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      if (k == ENTRIES - 1) begin : g_tail
        scd_cell #(.DEVICE_ID_BITS(DEVICE_ID_BITS)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .valid_in(wb_valid), .dev_in(wb_dev), .blk_in(wb_blk), .stamp_in(wb_stamp),
          .valid_out(cv[k]), .dev_out(cd[k]), .blk_out(cb[k]), .stamp_out(cs[k])
        );
      end else begin : g_body
        scd_cell #(.DEVICE_ID_BITS(DEVICE_ID_BITS)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .valid_in(cv[k+1]), .dev_in(cd[k+1]), .blk_in(cb[k+1]), .stamp_in(cs[k+1]),
          .valid_out(cv[k]), .dev_out(cd[k]), .blk_out(cb[k]), .stamp_out(cs[k])
        );
      end
    end
  endgenerate

  // control and captured word
  logic [1:0]                state;
  logic [IDX_W-1:0]          cnt;
  logic [OP_W-1:0]           op;
  logic [DEVICE_ID_BITS-1:0] dev;
  logic [BLK_W-1:0]          blk;
  logic [STAMP_W-1:0]        access_clock;
  logic [COUNT_W-1:0]        hits_seen;
  logic [COUNT_W-1:0]        misses_seen;

  // scan results
  logic                      found;
  logic [IDX_W-1:0]          found_idx;
  logic                      inv_found;
  logic [IDX_W-1:0]          inv_idx;
  logic [STAMP_W-1:0]        best_stamp;
  logic [IDX_W-1:0]          best_idx;
  logic [IDX_W-1:0]          victim;

  // pending result
  logic                      r_hit;
  logic [IDX_W-1:0]          r_idx;
  logic                      r_rej;

  logic [DEVICE_ID_BITS+DEV_PORT_W-1:0] dev_wide;
  logic [SLOT_W+IDX_W-1:0]              slot_wide;
  logic [STAMP_W-1:0]                   stamp_next;
  logic                                 head_match;
  logic                                 accept;
  logic                                 out_free;

  assign dev_wide   = {{DEVICE_ID_BITS{1'b0}}, device_id};
  assign slot_wide  = {{SLOT_W{1'b0}}, r_idx};
  assign stamp_next = access_clock + 1'b1;
  assign head_match = cv[0] && (cb[0] == blk) && (cd[0] == dev);
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign shift      = (state == S_SCAN) || (state == S_WRITE);
  assign victim     = found ? found_idx : (inv_found ? inv_idx : best_idx);

  // value handed back into the tail as the head entry leaves
  always_comb begin
    wb_valid = cv[0];
    wb_dev   = cd[0];
    wb_blk   = cb[0];
    wb_stamp = cs[0];
    if (state == S_SCAN) begin
      unique case (op)
        OP_GET: begin
          if (head_match) wb_stamp = stamp_next;
        end
        OP_INVALIDATE: begin
          if (head_match) wb_valid = 1'b0;
        end
        OP_FLUSH: begin
          if (cv[0] && (cd[0] == dev)) wb_valid = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (state == S_WRITE && cnt == victim) begin
      wb_valid = 1'b1;
      wb_dev   = dev;
      wb_blk   = blk;
      wb_stamp = stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      access_clock <= '0;
      hits_seen    <= '0;
      misses_seen  <= '0;
      out_valid    <= 1'b0;
      found        <= 1'b0;
      inv_found    <= 1'b0;
    end else begin
      // a taken word clears the register unless the next one loads it
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= operation;
            dev       <= dev_wide[DEVICE_ID_BITS-1:0];
            blk       <= block_address;
            cnt       <= '0;
            found     <= 1'b0;
            inv_found <= 1'b0;
            r_hit     <= 1'b0;
            r_idx     <= '0;
            r_rej     <= (operation == OP_PUT) && (sector_bytes > MAX_BYTES);
            if (operation == OP_PUT && sector_bytes > MAX_BYTES) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // first match, first invalid from slot 1, smallest stamp
          if (head_match && !found) begin
            found     <= 1'b1;
            found_idx <= cnt;
          end
          if (cnt != '0 && !cv[0] && !inv_found) begin
            inv_found <= 1'b1;
            inv_idx   <= cnt;
          end
          if (cnt == '0 || cs[0] < best_stamp) begin
            best_stamp <= cs[0];
            best_idx   <= cnt;
          end
          if (op == OP_GET && head_match) begin
            r_hit <= 1'b1;
            r_idx <= cnt;
          end
          if (op == OP_INVALIDATE && head_match) r_hit <= 1'b1;
          if (cnt == LAST_IDX) begin
            cnt <= '0;
            if (op == OP_PUT) begin
              state <= S_WRITE;
            end else begin
              if (op == OP_GET) begin
                if (found || head_match) begin
                  hits_seen    <= hits_seen + 1'b1;
                  access_clock <= stamp_next;
                end else begin
                  misses_seen <= misses_seen + 1'b1;
                end
              end
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WRITE: begin
          if (cnt == LAST_IDX) begin
            cnt          <= '0;
            r_idx        <= victim;
            access_clock <= stamp_next;
            state        <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      hit        <= r_hit;
      slot       <= slot_wide[SLOT_W-1:0];
      rejected   <= r_rej;
      hit_total  <= hits_seen;
      miss_total <= misses_seen;
    end
  end
endmodule

// File: rtl/scd_checker.sv
// port-level checks of the sector cache directory
module scd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           hit,
  input logic [scd_pkg::SLOT_W-1:0]     slot,
  input logic                           rejected,
  input logic [scd_pkg::COUNT_W-1:0]    hit_total,
  input logic [scd_pkg::COUNT_W-1:0]    miss_total
);
  import scd_pkg::*;

  // no word appears right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot) &&
      $stable(rejected) && $stable(hit_total) && $stable(miss_total))
    else $error("stalled word changed");

  // a rejected put reports neither hit nor slot
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> !hit && slot == '0)
    else $error("rejected word carries hit or slot");

  // one word at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");
endmodule

bind sector_cache_directory_lru scd_checker u_scd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .slot(slot),
  .rejected(rejected), .hit_total(hit_total), .miss_total(miss_total)
);

// File: tb/sv/sector_cache_directory_lru_checker.sv
// checker: lru directory predictor and result comparison
module sector_cache_directory_lru_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  device_id,
  input  logic [63:0] block_address,
  input  logic [12:0] sector_bytes,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [5:0]  slot,
  input  logic        rejected,
  input  logic [31:0] hit_total,
  input  logic [31:0] miss_total,
  output int          fail_count,
  output int          pending_words
);
  import scd_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        rejected;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_word_t;

  localparam int N = ENTRIES_DEF;

  logic        dir_valid [N];
  logic [7:0]  dir_dev [N];
  logic [63:0] dir_blk [N];
  logic [31:0] dir_stamp [N];
  logic [31:0] lru_clock, hits_cnt, miss_cnt;
  lookup_word_t expected_words[$];

  assign pending_words = expected_words.size();

  function automatic int find_entry(logic [7:0] d, logic [63:0] b);
    for (int i = 0; i < N; i++)
      if (dir_valid[i] && dir_blk[i] == b && dir_dev[i] == d) return i;
    return -1;
  endfunction

  function automatic int choose_victim();
    int best;
    logic [31:0] bs;
    best = 0;
    bs = dir_stamp[0];
    for (int i = 1; i < N; i++) begin
      if (!dir_valid[i]) return i;
      if (dir_stamp[i] < bs) begin
        bs = dir_stamp[i];
        best = i;
      end
    end
    return best;
  endfunction

  task automatic predict_word(logic [1:0] op, logic [7:0] d, logic [63:0] b,
                              logic [12:0] nb);
    lookup_word_t w;
    int idx;
    w = '0;
    if (op == OP_GET) begin
      idx = find_entry(d, b);
      if (idx >= 0) begin
        lru_clock++;
        dir_stamp[idx] = lru_clock;
        hits_cnt++;
        w.hit = 1'b1;
        w.slot = idx[5:0];
      end else miss_cnt++;
    end else if (op == OP_PUT) begin
      if (nb > MAX_SECTOR_BYTES_DEF) w.rejected = 1'b1;
      else begin
        idx = find_entry(d, b);
        if (idx < 0) idx = choose_victim();
        lru_clock++;
        dir_dev[idx] = d;
        dir_blk[idx] = b;
        dir_stamp[idx] = lru_clock;
        dir_valid[idx] = 1'b1;
        w.slot = idx[5:0];
      end
    end else if (op == OP_INVALIDATE) begin
      idx = find_entry(d, b);
      if (idx >= 0) begin
        dir_valid[idx] = 1'b0;
        w.hit = 1'b1;
      end
    end else begin
      for (int i = 0; i < N; i++)
        if (dir_valid[i] && dir_dev[i] == d) dir_valid[i] = 1'b0;
    end
    w.hit_total = hits_cnt;
    w.miss_total = miss_cnt;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    lookup_word_t e;
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        dir_valid[i] = 1'b0;
        dir_dev[i] = '0;
        dir_blk[i] = '0;
        dir_stamp[i] = '0;
      end
      lru_clock = '0;
      hits_cnt = '0;
      miss_cnt = '0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_word(operation, device_id, block_address, sector_bytes);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t unexpected word: actual %h", $time,
                   {hit, slot, rejected, hit_total, miss_total});
        end else begin
          e = expected_words.pop_front();
          if (e.hit !== hit) begin
            fail_count++;
            $display("%0t hit: expected %h actual %h", $time, e.hit, hit);
          end
          if (e.slot !== slot) begin
            fail_count++;
            $display("%0t slot: expected %0d actual %0d", $time, e.slot, slot);
          end
          if (e.rejected !== rejected) begin
            fail_count++;
            $display("%0t rejected: expected %h actual %h", $time, e.rejected, rejected);
          end
          if (e.hit_total !== hit_total) begin
            fail_count++;
            $display("%0t hit_total: expected %0d actual %0d", $time, e.hit_total,
                     hit_total);
          end
          if (e.miss_total !== miss_total) begin
            fail_count++;
            $display("%0t miss_total: expected %0d actual %0d", $time, e.miss_total,
                     miss_total);
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/sector_cache_directory_lru_tb.sv
// testbench top: stimulus, stall patterns and verdict for the lru directory
module sector_cache_directory_lru_tb;
  import scd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_GET;
  logic [7:0]  device_id = '0;
  logic [63:0] block_address = '0;
  logic [12:0] sector_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit, rejected;
  logic [5:0]  slot;
  logic [31:0] hit_total, miss_total;
  int          fail_count, pending_words;
  bit          hold_long = 1'b0;
  int          idle_cycles = 0;

  // small pools of tags so that gets and puts actually collide
  logic [63:0] blk_pool [8];
  logic [7:0]  dev_pool [4];

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sector_cache_directory_lru dut (.*);

  sector_cache_directory_lru_checker chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_word(logic [1:0] op, logic [7:0] d, logic [63:0] b,
                           logic [12:0] nb);
    operation <= op;
    device_id <= d;
    block_address <= b;
    sector_bytes <= nb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_input();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // random word: mostly from the pools, some fully random noise
  task automatic send_random();
    logic [1:0]  op;
    logic [7:0]  d;
    logic [63:0] b;
    logic [12:0] nb;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_GET;
    else if (r < 80) op = OP_PUT;
    else if (r < 93) op = OP_INVALIDATE;
    else op = OP_FLUSH;
    if ($urandom_range(0, 9) == 0) begin
      d = $urandom();
      b = {$urandom(), $urandom()};
    end else begin
      d = dev_pool[$urandom_range(0, 3)];
      b = blk_pool[$urandom_range(0, 7)] + $urandom_range(0, 11);
    end
    r = $urandom_range(0, 9);
    if (r == 0) nb = $urandom();
    else if (r == 1) nb = 13'd513;
    else nb = $urandom_range(0, 512);
    send_word(op, d, b, nb);
  endtask

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    int g;
    if (!rst) begin
      if (hold_long) out_stall <= 1'b1;
      else begin
        g = $urandom_range(0, 99);
        if (g < 60) out_stall <= 1'b0;
        else if (g < 97) out_stall <= 1'b1;
        else begin
          out_stall <= 1'b1;
          for (int k = 0; k < $urandom_range(20, 120); k++) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no accepted input word and no taken output word
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[sector_cache_directory_lru] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) blk_pool[i] = {$urandom(), $urandom()};
    blk_pool[0] = '0;
    blk_pool[1] = '1 - 64'd16;
    dev_pool[0] = 8'h00;
    dev_pool[1] = 8'hff;
    dev_pool[2] = $urandom();
    dev_pool[3] = $urandom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: miss on empty, extremes, hit, re-put, oversize, invalidate, flush
    send_word(OP_GET, 8'h00, 64'd0, 13'd0);
    send_word(OP_PUT, 8'h00, 64'd0, 13'd512);
    send_word(OP_PUT, 8'hff, '1, 13'd0);
    send_word(OP_GET, 8'hff, '1, 13'h1fff);
    send_word(OP_GET, 8'h00, 64'd0, 13'd0);
    send_word(OP_PUT, 8'h00, 64'd0, 13'd100);
    send_word(OP_PUT, 8'h12, 64'd5, 13'd513);
    send_word(OP_PUT, 8'h12, 64'd5, 13'h1fff);
    send_word(OP_GET, 8'h12, 64'd5, 13'd0);
    send_word(OP_INVALIDATE, 8'hff, '1, 13'd0);
    send_word(OP_INVALIDATE, 8'hff, '1, 13'd0);
    send_word(OP_PUT, 8'h00, 64'd7, 13'd1);
    send_word(OP_FLUSH, 8'h00, 64'd0, 13'd0);
    send_word(OP_GET, 8'h00, 64'd7, 13'd0);
    send_word(OP_FLUSH, 8'haa, 64'h5555, 13'd0);
    // fill past capacity so victims come from stamps, slot 0 included
    for (int i = 0; i < 70; i++) send_word(OP_PUT, 8'h01, 64'(i), 13'd64);
    send_word(OP_GET, 8'h01, 64'd69, 13'd0);

    // long receiver hold-off while input keeps flowing
    hold_long = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_long = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_random();
    join

    for (int n = 0; n < 1300; n++) begin
      send_random();
      pause_input();
    end
    in_valid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("[sector_cache_directory_lru] OK");
    else
      $display("[sector_cache_directory_lru] ERROR");
    $finish;
  end
endmodule
